// File: design/ktt_pkg.sv
// ----------------------------------------------------------------------------
// ktt_pkg: shared types and constants of the keyed tally table
// Table geometry, slot and result word layouts, command codes.
// ----------------------------------------------------------------------------
package ktt_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 64;
    localparam int COUNT_BITS = 32;

    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam int IN_KEY_W   = 64;
    localparam int AMOUNT_W   = 8;
    localparam int KCOUNT_W   = 32;
    localparam int TOTAL_W    = 38;
    localparam int OUT_KEY_W  = 64;
    localparam int SUM_W      = ((TOTAL_W > COUNT_BITS) ? TOTAL_W : COUNT_BITS) + 1;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 208;

    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic {
        CMD_TALLY  = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } t_slot;

    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic [IN_KEY_W-1:0] key;
    } t_in_data;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [5:0]           pad;
        logic [OUT_KEY_W-1:0] min_key;
        logic                 has_min;
        logic [OUT_KEY_W-1:0] max_key;
        logic                 has_max;
        logic [TOTAL_W-1:0]   grand_total;
        logic [KCOUNT_W-1:0]  key_count;
        logic                 table_full;
        logic                 found;
    } t_result;

endpackage

// File: design/keyed_tally_table.sv
// ----------------------------------------------------------------------------
// keyed_tally_table: bounded associative tally table
// Finds a key in slot memory (a tally inserts it if new), adds a tally's amount
// with saturation, then walks filled slots for total, maximum and minimum key.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                         word contents (low bit up)
//  --------  ---  ------------------------------  ---------------------------
//  s_axis    in   tvalid tready tdata[71:0]       key[63:0] amount[71:64]
//                 tuser[0:0]                      cmd (0 tally, 1 lookup)
//  m_axis    out  tvalid tready tdata[207:0]      found, table_full,
//                                                 key_count[32], grand_total[38],
//                                                 has_max, max_key[64],
//                                                 has_min, min_key[64], 6 zeros
//
//  For each item the single read port of the slot memory is swept once to
//  search and once to sum, one slot per cycle, over the filled slots only.
//  The search stops early on a hit. Reset (synchronous, active low) empties
//  the table at once through the fill count; slot contents need no clearing.
//  A finished result holds in the output register while m_axis stalls; the
//  next input word is taken during that stall and stops only at the end of
//  its walk if the previous result is still waiting.
//
module keyed_tally_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key[63:0], amount[71:64]
    input  logic [ktt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd[0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // found[0], table_full[1], key_count[33:2], grand_total[71:34], has_max[72],
    // max_key[136:73], has_min[137], min_key[201:138], zero pad[207:202]
    output logic [ktt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    // slot memory: one write port, one registered read port
    ktt_pkg::t_slot                     r_mem [ktt_pkg::ENTRIES];
    ktt_pkg::t_slot                     r_rdata;

    t_state                             r_state, n_state;
    logic [ktt_pkg::CNT_W-1:0]          r_used, n_used;
    logic [ktt_pkg::CNT_W-1:0]          r_idx, n_idx;
    logic                               r_pend, n_pend;
    logic [ktt_pkg::IDX_W-1:0]          r_pend_idx, n_pend_idx;
    logic                               r_out_valid, n_out_valid;

    ktt_pkg::t_cmd                      r_cmd, n_cmd;
    logic [ktt_pkg::KEY_BITS-1:0]       r_key, n_key;
    logic [ktt_pkg::AMOUNT_W-1:0]       r_amount, n_amount;
    logic                               r_found, n_found;
    logic [ktt_pkg::IDX_W-1:0]          r_hit, n_hit;
    logic [ktt_pkg::COUNT_BITS-1:0]     r_cnt, n_cnt;
    logic                               r_full, n_full;
    logic [ktt_pkg::COUNT_BITS-1:0]     r_kcount, n_kcount;
    logic [ktt_pkg::TOTAL_W-1:0]        r_total, n_total;
    logic [ktt_pkg::COUNT_BITS-1:0]     r_maxv, n_maxv;
    logic [ktt_pkg::KEY_BITS-1:0]       r_maxk, n_maxk;
    logic                               r_has_max, n_has_max;
    logic [ktt_pkg::COUNT_BITS-1:0]     r_minv, n_minv;
    logic [ktt_pkg::KEY_BITS-1:0]       r_mink, n_mink;
    ktt_pkg::t_result                   r_result, n_result;

    // memory port controls
    logic                               mem_we;
    logic [ktt_pkg::IDX_W-1:0]          mem_waddr;
    ktt_pkg::t_slot                     mem_wdata;
    logic [ktt_pkg::IDX_W-1:0]          mem_raddr;

    ktt_pkg::t_in_data                  in_data;
    logic                               in_accept;
    logic                               issue;
    logic                               is_tally;
    logic                               can_insert;
    logic [ktt_pkg::COUNT_BITS:0]       cnt_sum;
    logic [ktt_pkg::COUNT_BITS-1:0]     new_cnt;
    logic [ktt_pkg::SUM_W-1:0]          tot_sum;
    logic                               has_min;
    logic                               out_free;

    assign in_data       = ktt_pkg::t_in_data'(s_axis_tdata);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ktt_pkg::OUT_DATA_W'(r_result);
    assign out_free      = !r_out_valid || m_axis_tready;

    // one read per cycle while slots remain in the sweep
    assign issue      = (r_idx != r_used);
    assign mem_raddr  = r_idx[ktt_pkg::IDX_W-1:0];

    // update step: saturating add onto the found count, or onto zero for a new slot
    assign is_tally   = (r_cmd == ktt_pkg::CMD_TALLY);
    assign can_insert = (r_used != ktt_pkg::CNT_W'(ktt_pkg::ENTRIES));
    assign cnt_sum    = {1'b0, (r_found ? r_cnt : '0)}
                        + (ktt_pkg::COUNT_BITS + 1)'(r_amount);
    assign new_cnt    = cnt_sum[ktt_pkg::COUNT_BITS] ? ktt_pkg::COUNT_MAX
                                                     : cnt_sum[ktt_pkg::COUNT_BITS-1:0];

    assign mem_we     = (r_state == ST_UPDATE) && is_tally && (r_found || can_insert);
    assign mem_waddr  = r_found ? r_hit : r_used[ktt_pkg::IDX_W-1:0];
    assign mem_wdata  = '{key: r_key, count: new_cnt};

    // walk step: saturating running total
    assign tot_sum    = ktt_pkg::SUM_W'(r_total) + ktt_pkg::SUM_W'(r_rdata.count);
    assign has_min    = (r_used != '0) && (r_minv != '0);

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_idx[ktt_pkg::IDX_W-1:0];
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_amount    = r_amount;
        n_found     = r_found;
        n_hit       = r_hit;
        n_cnt       = r_cnt;
        n_full      = r_full;
        n_kcount    = r_kcount;
        n_total     = r_total;
        n_maxv      = r_maxv;
        n_maxk      = r_maxk;
        n_has_max   = r_has_max;
        n_minv      = r_minv;
        n_mink      = r_mink;
        n_result    = r_result;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_cmd    = ktt_pkg::t_cmd'(s_axis_tuser[0]);
                    n_key    = in_data.key[ktt_pkg::KEY_BITS-1:0];
                    n_amount = in_data.amount;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_state  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // issue the next read while comparing the previous one
                if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend && (r_rdata.key == r_key)) begin
                    n_found = 1'b1;
                    n_hit   = r_pend_idx;
                    n_cnt   = r_rdata.count;
                    n_pend  = 1'b0;
                    n_state = ST_UPDATE;
                end else if (!r_pend && !issue) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (is_tally && !r_found && can_insert) begin
                    n_used = r_used + 1'b1;
                end
                n_full    = is_tally && !r_found && !can_insert;
                n_kcount  = mem_we ? new_cnt : (r_found ? r_cnt : '0);
                n_idx     = '0;
                n_total   = '0;
                n_maxv    = '0;
                n_maxk    = '0;
                n_has_max = 1'b0;
                n_minv    = '1;
                n_mink    = '0;
                n_state   = ST_WALK;
            end
            ST_WALK: begin
                if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend) begin
                    n_total = (tot_sum > ktt_pkg::SUM_W'(ktt_pkg::TOTAL_MAX))
                              ? ktt_pkg::TOTAL_MAX : ktt_pkg::TOTAL_W'(tot_sum);
                    // first strictly largest count wins
                    if (r_rdata.count > r_maxv) begin
                        n_maxv    = r_rdata.count;
                        n_maxk    = r_rdata.key;
                        n_has_max = 1'b1;
                    end
                    // last smallest count wins
                    if (r_rdata.count <= r_minv) begin
                        n_minv = r_rdata.count;
                        n_mink = r_rdata.key;
                    end
                end else if (!issue) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register frees up
                if (out_free) begin
                    n_result.pad         = '0;
                    n_result.found       = r_found;
                    n_result.table_full  = r_full;
                    n_result.key_count   = ktt_pkg::KCOUNT_W'(r_kcount);
                    n_result.grand_total = r_total;
                    n_result.has_max     = r_has_max;
                    n_result.max_key     = ktt_pkg::OUT_KEY_W'(r_maxk);
                    n_result.has_min     = has_min;
                    n_result.min_key     = has_min ? ktt_pkg::OUT_KEY_W'(r_mink) : '0;
                    n_out_valid          = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_amount   <= n_amount;
        r_found    <= n_found;
        r_hit      <= n_hit;
        r_cnt      <= n_cnt;
        r_full     <= n_full;
        r_kcount   <= n_kcount;
        r_total    <= n_total;
        r_maxv     <= n_maxv;
        r_maxk     <= n_maxk;
        r_has_max  <= n_has_max;
        r_minv     <= n_minv;
        r_mink     <= n_mink;
        r_result   <= n_result;
    end

    // slot memory; a write in the update cycle is seen by the walk's first read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule

// File: design/ktt_checker.sv
// ----------------------------------------------------------------------------
// ktt_checker: port-level checks of the keyed tally table
// Output handshake hold, result flag consistency, busy after an accept.
// ----------------------------------------------------------------------------
module ktt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ktt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    ktt_pkg::t_result res;

    assign res = ktt_pkg::t_result'(m_axis_tdata);

    // a waiting result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed while stalled");

    // a dropped tally reports neither a hit nor a count
    a_full_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.table_full |-> !res.found && (res.key_count == '0))
        else $error("table_full with found or nonzero count");

    // absent extremes read as zero keys
    a_no_ext_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.has_max || (res.max_key == '0))
                          && (res.has_min || (res.min_key == '0)))
        else $error("extreme key set without its flag");

    // a nonzero minimum implies a nonzero maximum
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.has_min |-> res.has_max)
        else $error("has_min without has_max");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

endmodule

bind keyed_tally_table ktt_checker u_ktt_checker (.*);
